// ===== design/nps_pkg.sv =====
// Shared types and constants for the nearest point search block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package nps_pkg;

   localparam int COORD_BITS = 16;
   localparam int ID_BITS    = 48;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                         op;
      logic [ID_BITS-1:0]           point_id;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ID_BITS-1:0]   nearest_id;
      logic [DIST_BITS-1:0] nearest_dist_sq;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0]           id;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } entry_type;

   // travels alongside each point read during a scan
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } scan_tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

endpackage

// ===== design/nps_mem.sv =====
// Point table: one write port, one registered read port.
// Depends on nps_pkg for the entry type.
`timescale 1ns / 1ps

module nps_mem #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  nps_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output nps_pkg::entry_type rd_data
);
   import nps_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/nps_dist.sv =====
// Distance unit: absolute differences, then squares, one stage each.
// Depends on nps_pkg for entry and tag types.
`timescale 1ns / 1ps

module nps_dist (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nps_pkg::scan_tag_type                 tag_in,
   input  nps_pkg::entry_type                    point,
   input  logic signed [nps_pkg::COORD_BITS-1:0] qx,
   input  logic signed [nps_pkg::COORD_BITS-1:0] qy,
   output nps_pkg::scan_tag_type                 tag_out,
   output logic [nps_pkg::ID_BITS-1:0]           id_out,
   output logic [nps_pkg::SQ_BITS-1:0]           sq_x,
   output logic [nps_pkg::SQ_BITS-1:0]           sq_y
);
   import nps_pkg::*;

   logic signed [COORD_BITS:0] diff_x, diff_y;
   logic [COORD_BITS:0]        mag_x, mag_y;
   logic [COORD_BITS-1:0]      abs_x_in, abs_y_in, abs_x_ff, abs_y_ff;
   logic [ID_BITS-1:0]         id1_ff, id2_ff;
   scan_tag_type               tag1_ff, tag2_ff;
   logic [SQ_BITS-1:0]         sq_x_in, sq_y_in, sq_x_ff, sq_y_ff;

   always_comb begin
      diff_x   = {point.x[COORD_BITS-1], point.x} - {qx[COORD_BITS-1], qx};
      diff_y   = {point.y[COORD_BITS-1], point.y} - {qy[COORD_BITS-1], qy};
      mag_x    = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : diff_x;
      mag_y    = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : diff_y;
      abs_x_in = mag_x[COORD_BITS-1:0];
      abs_y_in = mag_y[COORD_BITS-1:0];
      sq_x_in  = SQ_BITS'(abs_x_ff) * SQ_BITS'(abs_x_ff);
      sq_y_in  = SQ_BITS'(abs_y_ff) * SQ_BITS'(abs_y_ff);
   end

   always_ff @(posedge clock) begin
      abs_x_ff <= abs_x_in;
      abs_y_ff <= abs_y_in;
      id1_ff   <= point.id;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      id2_ff   <= id1_ff;
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   assign tag_out = tag2_ff;
   assign id_out  = id2_ff;
   assign sq_x    = sq_x_ff;
   assign sq_y    = sq_y_ff;

endmodule

// ===== design/nearest_point_search.sv =====
// Top level of the nearest point search block: sequencer, table and compare stage.
// Depends on nps_pkg, nps_mem and nps_dist.
`timescale 1ns / 1ps

// Usage:
//   An item is taken when start is high and busy is low. op selects a load
//   (store point_id, coord_x, coord_y in the next free slot) or a query
//   (find the stored point nearest to coord_x, coord_y).
//   Each item gives one result, shown on rsp_item for exactly one cycle with
//   rsp_valid high; the receiver must take it then, it cannot stall.
//   busy stays high from the cycle after an item is taken through the cycle
//   in which its result is shown.
//   Load, and query on an empty table: result in the cycle after the item is taken.
//   Query over N stored points: one table read per cycle through a single
//   read port, then a 3 stage distance and compare pipeline; the result
//   shows once the last point has passed the compare stage.
//   Reset empties the table (count to zero); no clearing pass.
//   Ties go to the point stored first.

module nearest_point_search #(
   parameter int MAX_POINTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nps_pkg::req_type req_item,
   output logic             rsp_valid,
   output nps_pkg::rsp_type rsp_item
);
   import nps_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in, count_minus;
   logic [AW-1:0]                rd_idx_ff, rd_idx_in, last_idx;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   logic [ID_BITS-1:0]           best_id_ff, best_id_in;
   logic [DIST_BITS-1:0]         best_dist_ff, best_dist_in, dist_sum;
   rsp_type                      rsp_ff, rsp_in;

   logic         accept, is_load, full, scan_last, better, cmp_done;
   logic         wr_en, rd_en;
   entry_type    wr_data, rd_data;
   scan_tag_type tag_rd, tag_mem_ff, tag_cmp;
   logic [ID_BITS-1:0] cmp_id;
   logic [SQ_BITS-1:0] sq_x, sq_y;

   assign accept      = start & ~busy;
   assign is_load     = req_item.op == OP_LOAD;
   assign full        = count_ff == CW'(MAX_POINTS);
   assign count_minus = count_ff - CW'(1);
   assign last_idx    = count_minus[AW-1:0];
   assign scan_last   = rd_idx_ff == last_idx;
   assign cmp_done    = tag_cmp.valid & tag_cmp.last;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (is_load || count_ff == '0) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmp_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      rd_en        = 1'b0;
      tag_rd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_SCAN: begin
            rd_en        = 1'b1;
            tag_rd.valid = 1'b1;
            tag_rd.first = rd_idx_ff == '0;
            tag_rd.last  = scan_last;
         end
         ST_DRAIN: begin
            busy = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign wr_en      = accept & is_load & ~full;
   assign wr_data.id = req_item.point_id;
   assign wr_data.x  = req_item.coord_x;
   assign wr_data.y  = req_item.coord_y;

   nps_mem #(
      .DEPTH (MAX_POINTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   nps_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag_mem_ff),
      .point   (rd_data),
      .qx      (qx_ff),
      .qy      (qy_ff),
      .tag_out (tag_cmp),
      .id_out  (cmp_id),
      .sq_x    (sq_x),
      .sq_y    (sq_y)
   );

   // compare stage and result
   always_comb begin
      dist_sum     = DIST_BITS'(sq_x) + DIST_BITS'(sq_y);
      better       = tag_cmp.first || (dist_sum < best_dist_ff);
      best_id_in   = best_id_ff;
      best_dist_in = best_dist_ff;
      if (tag_cmp.valid && better) begin
         best_id_in   = cmp_id;
         best_dist_in = dist_sum;
      end

      rsp_in = rsp_ff;
      if (accept) begin
         rsp_in = '0;
         if (is_load) begin
            rsp_in.status = full ? STATUS_FULL : STATUS_OK;
         end else if (count_ff == '0) begin
            rsp_in.status = STATUS_EMPTY;
         end
      end else if (cmp_done) begin
         rsp_in.status          = STATUS_OK;
         rsp_in.nearest_id      = best_id_in;
         rsp_in.nearest_dist_sq = best_dist_in;
      end

      count_in = wr_en ? count_ff + CW'(1) : count_ff;

      rd_idx_in = rd_idx_ff;
      if (state_ff == ST_IDLE) begin
         rd_idx_in = '0;
      end else if (state_ff == ST_SCAN) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         tag_mem_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         tag_mem_ff <= tag_rd;
      end
      rd_idx_ff    <= rd_idx_in;
      best_id_ff   <= best_id_in;
      best_dist_ff <= best_dist_in;
      rsp_ff       <= rsp_in;
      if (accept) begin
         qx_ff <= req_item.coord_x;
         qy_ff <= req_item.coord_y;
      end
   end

   assign rsp_item = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while not busy");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && is_load) |=> rsp_valid)
      else $error("load result not shown in the next cycle");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block not idle after result");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_FULL) |-> full)
      else $error("table full reported with free slots");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for nearest_point_search: loads points, runs nearest-point queries
// and checks every result against a scan of its own copy of the point table.
// Depends on nps_pkg and the nearest_point_search RTL.
`timescale 1ns / 1ps

module tb_top;
   import nps_pkg::*;

   localparam int TABLE_DEPTH  = 1024;
   localparam int RANDOM_ITEMS = 564;
   localparam int RSP_SLOTS    = 16;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   nearest_point_search #(.MAX_POINTS(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of the point table
   logic [ID_BITS-1:0]           stored_ids [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] stored_xs  [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] stored_ys  [TABLE_DEPTH];
   int                           stored_count = 0;

   // expected results, in order of acceptance
   rsp_type pending_rsps [RSP_SLOTS];
   int      rsp_wr = 0;
   int      rsp_rd = 0;
   rsp_type want;
   int      mismatch_count = 0;
   int      burst_left = 0;

   function automatic rsp_type predict_nearest(input req_type r);
      rsp_type res;
      longint  dx, dy, d, best;
      res  = '0;
      best = 0;
      if (r.op == OP_LOAD) begin
         if (stored_count >= TABLE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            stored_ids[stored_count] = r.point_id;
            stored_xs[stored_count]  = r.coord_x;
            stored_ys[stored_count]  = r.coord_y;
            stored_count++;
         end
      end else if (stored_count == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         for (int i = 0; i < stored_count; i++) begin
            dx = longint'(stored_xs[i]) - longint'(r.coord_x);
            dy = longint'(stored_ys[i]) - longint'(r.coord_y);
            d  = dx * dx + dy * dy;
            // strict compare: earliest stored point keeps a tie
            if (i == 0 || d < best) begin
               best           = d;
               res.nearest_id = stored_ids[i];
            end
         end
         res.nearest_dist_sq = best[DIST_BITS-1:0];
      end
      return res;
   endfunction

   function automatic logic [ID_BITS-1:0] rand_id();
      return ID_BITS'({$urandom, $urandom});
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      logic signed [COORD_BITS-1:0] corners [6] = '{-32768, -32767, -1, 0, 1, 32767};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return COORD_BITS'(int'($urandom_range(0, 32)) - 16);
         4:          return corners[$urandom_range(0, 5)];
         default:    return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic req_type make_item(input logic op, input logic [ID_BITS-1:0] id,
                                         input int x, input int y);
      req_type r;
      r.op       = op;
      r.point_id = id;
      r.coord_x  = COORD_BITS'(x);
      r.coord_y  = COORD_BITS'(y);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%t: %s", $realtime, what);
   endtask

   // bursts of back-to-back items separated by random gaps
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 40)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
      end
   endtask

   task automatic send_item(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      pending_rsps[rsp_wr % RSP_SLOTS] = predict_nearest(r);
      rsp_wr++;
      pace_sender();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_wr == rsp_rd) begin
            report_mismatch($sformatf("unexpected result status=%0d id=%h dist=%0d",
                                      rsp_item.status, rsp_item.nearest_id,
                                      rsp_item.nearest_dist_sq));
         end else begin
            want = pending_rsps[rsp_rd % RSP_SLOTS];
            rsp_rd++;
            if (rsp_item.status !== want.status || rsp_item.nearest_id !== want.nearest_id
                || rsp_item.nearest_dist_sq !== want.nearest_dist_sq)
               report_mismatch($sformatf(
                  "mismatch: expected status=%0d id=%h dist=%0d, got status=%0d id=%h dist=%0d",
                  want.status, want.nearest_id, want.nearest_dist_sq,
                  rsp_item.status, rsp_item.nearest_id, rsp_item.nearest_dist_sq));
         end
      end
   end

   task automatic test_empty_and_corners();
      send_item(make_item(OP_QUERY, rand_id(), 123, -456));
      send_item(make_item(OP_LOAD, {ID_BITS{1'b1}}, -32768, -32768));
      send_item(make_item(OP_QUERY, rand_id(), 32767, 32767));
      send_item(make_item(OP_QUERY, '0, -32768, -32768));
      send_item(make_item(OP_LOAD, '0, 32767, 32767));
      send_item(make_item(OP_QUERY, rand_id(), 32767, -32768));
      send_item(make_item(OP_QUERY, rand_id(), 0, 0));
      send_item(make_item(OP_QUERY, rand_id(), -1, -1));
   endtask

   task automatic test_ties();
      send_item(make_item(OP_LOAD, 48'h5555_5555_5555, 5, 5));
      send_item(make_item(OP_LOAD, 48'hAAAA_AAAA_AAAA, 5, 5));
      send_item(make_item(OP_QUERY, rand_id(), 5, 5));
      send_item(make_item(OP_QUERY, rand_id(), 6, 5));
      send_item(make_item(OP_LOAD, 48'h0000_0000_0C0C, 10, 0));
      send_item(make_item(OP_LOAD, 48'h0000_0000_0D0D, -10, 0));
      send_item(make_item(OP_QUERY, rand_id(), 0, -40));
      send_item(make_item(OP_QUERY, rand_id(), 0, 40));
   endtask

   task automatic test_random_mix();
      int      idx;
      req_type r;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (stored_count == 0 || $urandom_range(0, 99) < 35) begin
            r = make_item(OP_LOAD, rand_id(), pick_coord(), pick_coord());
         end else begin
            r = make_item(OP_QUERY, rand_id(), pick_coord(), pick_coord());
            idx = $urandom_range(0, stored_count - 1);
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  r.coord_x = stored_xs[idx];
                  r.coord_y = stored_ys[idx];
               end
               3: begin
                  r.coord_x = stored_xs[idx] + COORD_BITS'(int'($urandom_range(0, 4)) - 2);
                  r.coord_y = stored_ys[idx] + COORD_BITS'(int'($urandom_range(0, 4)) - 2);
               end
               default: ;
            endcase
         end
         send_item(r);
      end
   endtask

   initial begin
      int waited;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_corners();
      test_ties();
      test_random_mix();
      start <= 1'b0;

      waited = 0;
      while (rsp_wr != rsp_rd && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (rsp_wr != rsp_rd)
         report_mismatch($sformatf("%0d results never arrived", rsp_wr - rsp_rd));

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
